// File: sv/rmpa_pkg.sv
// shared types and constants for the refcounted message pool allocator
`default_nettype none
package rmpa_pkg;

  localparam int unsigned SMALL_UNITS = 8;
  localparam int unsigned LARGE_UNITS = 16;
  localparam int unsigned ENTRY_COUNT = SMALL_UNITS + LARGE_UNITS;

  localparam int unsigned IDX_W       = 4;
  localparam int unsigned LINK_W      = 5;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned REF_W       = 8;
  localparam int unsigned LIMIT_W     = 8;
  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned HDR_W       = 3 * FIELD_W;
  localparam int unsigned SLOT_W      = $clog2(ENTRY_COUNT);
  localparam int unsigned SMALL_IDX_W = (SMALL_UNITS > 1) ? $clog2(SMALL_UNITS) : 1;
  localparam int unsigned LARGE_IDX_W = (LARGE_UNITS > 1) ? $clog2(LARGE_UNITS) : 1;

  localparam logic [LINK_W-1:0]  LINK_END      = '1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 8'd16;
  localparam logic [REF_W-1:0]   REF_MAX       = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX       = '1;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_ADD_REF  = 2'd2,
    OP_DROP_REF = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TOO_LARGE  = 2'd1,
    ST_EXHAUSTED  = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// File: sv/rmpa_ram.sv
// generic single write port ram with registered read
`default_nettype none
module rmpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: sv/rmpa_ctrl.sv
// controller state machine: sequences capture and execution of one operation
`default_nettype none
module rmpa_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire rmpa_pkg::dp_status_t   status_i,
  output rmpa_pkg::ctrl_cmd_t         cmd_o
);
  import rmpa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.execute = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/rmpa_dpath.sv
// datapath: free lists, counts, reference counts and the result register
`default_nettype none
module rmpa_dpath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rmpa_pkg::ctrl_cmd_t           cmd_i,
  output rmpa_pkg::dp_status_t               status_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [rmpa_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  wire logic [1:0]                    operation_i,
  input  wire logic [rmpa_pkg::FIELD_W-1:0]  dest_task_i,
  input  wire logic [rmpa_pkg::FIELD_W-1:0]  signal_code_i,
  input  wire logic [rmpa_pkg::FIELD_W-1:0]  payload_size_i,
  input  wire logic [rmpa_pkg::FIELD_W-1:0]  source_task_i,
  input  wire logic                          handle_pool_i,
  input  wire logic [rmpa_pkg::IDX_W-1:0]    handle_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         status_o_field,
  output logic                               result_pool_o,
  output logic [rmpa_pkg::IDX_W-1:0]         result_index_o,
  output logic [rmpa_pkg::REF_W-1:0]         ref_count_now_o,
  output logic [rmpa_pkg::CNT_W-1:0]         in_use_now_o,
  output logic [rmpa_pkg::CNT_W-1:0]         peak_in_use_o,
  output logic                               released_o
);
  import rmpa_pkg::*;

  // captured transaction
  op_e                op_q;
  logic [FIELD_W-1:0] size_q;
  logic [HDR_W-1:0]   hdr_q;
  logic               hpool_q;
  logic [IDX_W-1:0]   hidx_q;

  logic [LIMIT_W-1:0] limit_q;

  logic [LINK_W-1:0] small_head_q, large_head_q;
  logic [LINK_W-1:0] small_link_q [SMALL_UNITS];
  logic [LINK_W-1:0] large_link_q [LARGE_UNITS];
  logic [CNT_W-1:0]  in_use_q [2];
  logic [CNT_W-1:0]  peak_q [2];
  logic [REF_W-1:0]  refs_q [ENTRY_COUNT];
  logic              busy_q [ENTRY_COUNT];

  logic              out_valid_q;
  status_e           res_status_q;
  logic              res_pool_q;
  logic [IDX_W-1:0]  res_idx_q;
  logic [REF_W-1:0]  res_refs_q;
  logic [CNT_W-1:0]  res_use_q, res_peak_q;
  logic              res_rel_q;

  // execution logic
  logic              too_large, pool_sel, exhausted, range_ok, busy_hit;
  logic [LINK_W-1:0] head, rel_head;
  logic [SLOT_W-1:0] hslot, aslot;
  logic [REF_W-1:0]  cur_refs, new_refs;
  logic              do_alloc, do_release, do_refwr;
  status_e           res_status;
  logic              res_pool;
  logic [IDX_W-1:0]  res_idx;
  logic [REF_W-1:0]  res_refs;
  logic              res_rel;
  logic [CNT_W-1:0]  use_cur, peak_cur, use_nxt, peak_nxt;
  logic [HDR_W-1:0]  unused_hdr_rd;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    too_large = (size_q != '0) && (size_q > FIELD_W'(limit_q));
    pool_sel  = (size_q != '0);
    head      = pool_sel ? large_head_q : small_head_q;
    exhausted = head >= (pool_sel ? LINK_W'(LARGE_UNITS) : LINK_W'(SMALL_UNITS));
    aslot     = pool_sel ? SLOT_W'(SMALL_UNITS) + SLOT_W'(head) : SLOT_W'(head);

    range_ok  = LINK_W'(hidx_q) < (hpool_q ? LINK_W'(LARGE_UNITS) : LINK_W'(SMALL_UNITS));
    hslot     = hpool_q ? SLOT_W'(SMALL_UNITS) + SLOT_W'(hidx_q) : SLOT_W'(hidx_q);
    busy_hit  = range_ok && busy_q[hslot];
    cur_refs  = range_ok ? refs_q[hslot] : '0;
    rel_head  = hpool_q ? large_head_q : small_head_q;

    res_status = ST_OK;
    res_pool   = hpool_q;
    res_idx    = hidx_q;
    res_refs   = '0;
    res_rel    = 1'b0;
    do_alloc   = 1'b0;
    do_release = 1'b0;
    do_refwr   = 1'b0;
    new_refs   = cur_refs;

    if (op_q == OP_ALLOC) begin
      res_idx = '0;
      if (too_large) begin
        res_status = ST_TOO_LARGE;
        res_pool   = 1'b1;
      end else if (exhausted) begin
        res_status = ST_EXHAUSTED;
        res_pool   = pool_sel;
      end else begin
        do_alloc = 1'b1;
        res_pool = pool_sel;
        res_idx  = head[IDX_W-1:0];
        res_refs = REF_W'(1);
      end
    end else if (!busy_hit) begin
      res_status = ST_BAD_HANDLE;
    end else begin
      unique case (op_q)
        OP_FREE: begin
          do_release = 1'b1;
          res_rel    = 1'b1;
        end
        OP_ADD_REF: begin
          // saturates at the top of the count
          new_refs = (cur_refs == REF_MAX) ? cur_refs : cur_refs + REF_W'(1);
          do_refwr = 1'b1;
          res_refs = new_refs;
        end
        OP_DROP_REF: begin
          new_refs = (cur_refs == '0) ? cur_refs : cur_refs - REF_W'(1);
          if (new_refs == '0) begin
            do_release = 1'b1;
            res_rel    = 1'b1;
          end else begin
            do_refwr = 1'b1;
            res_refs = new_refs;
          end
        end
        OP_ALLOC: ;
        default: ;
      endcase
    end

    use_cur  = in_use_q[res_pool];
    peak_cur = peak_q[res_pool];
    use_nxt  = use_cur;
    if (do_alloc && use_cur != CNT_MAX) begin
      use_nxt = use_cur + CNT_W'(1);
    end else if (do_release && use_cur != '0) begin
      use_nxt = use_cur - CNT_W'(1);
    end
    peak_nxt = (use_nxt > peak_cur) ? use_nxt : peak_cur;
  end

  // captured fields carry no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_e'(operation_i);
      size_q  <= payload_size_i;
      hdr_q   <= {source_task_i, dest_task_i, signal_code_i};
      hpool_q <= handle_pool_i;
      hidx_q  <= handle_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      <= LIMIT_RESET;
      small_head_q <= '0;
      large_head_q <= '0;
      for (int i = 0; i < SMALL_UNITS; i++) begin
        small_link_q[i] <= (i + 1 < SMALL_UNITS) ? LINK_W'(i + 1) : LINK_END;
      end
      for (int i = 0; i < LARGE_UNITS; i++) begin
        large_link_q[i] <= (i + 1 < LARGE_UNITS) ? LINK_W'(i + 1) : LINK_END;
      end
      for (int i = 0; i < 2; i++) begin
        in_use_q[i] <= '0;
        peak_q[i]   <= '0;
      end
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        refs_q[i] <= '0;
        busy_q[i] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.execute) begin
        if (do_alloc) begin
          // pop the head of the selected free list
          if (pool_sel) begin
            large_head_q <= large_link_q[head[LARGE_IDX_W-1:0]];
          end else begin
            small_head_q <= small_link_q[head[SMALL_IDX_W-1:0]];
          end
          busy_q[aslot] <= 1'b1;
          refs_q[aslot] <= REF_W'(1);
        end
        if (do_release) begin
          // push the entry back on its free list
          if (hpool_q) begin
            large_link_q[hidx_q[LARGE_IDX_W-1:0]] <= rel_head;
            large_head_q <= LINK_W'(hidx_q);
          end else begin
            small_link_q[hidx_q[SMALL_IDX_W-1:0]] <= rel_head;
            small_head_q <= LINK_W'(hidx_q);
          end
          busy_q[hslot] <= 1'b0;
          refs_q[hslot] <= '0;
        end
        if (do_refwr) begin
          refs_q[hslot] <= new_refs;
        end
        in_use_q[res_pool] <= use_nxt;
        peak_q[res_pool]   <= peak_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.execute) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      res_status_q <= res_status;
      res_pool_q   <= res_pool;
      res_idx_q    <= res_idx;
      res_refs_q   <= res_refs;
      res_use_q    <= use_nxt;
      res_peak_q   <= peak_nxt;
      res_rel_q    <= res_rel;
    end
  end

  // message headers: written on allocate, read port kept for debug access
  rmpa_ram #(
    .WIDTH (HDR_W),
    .DEPTH (ENTRY_COUNT)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.execute && do_alloc),
    .waddr_i (aslot),
    .wdata_i (hdr_q),
    .raddr_i (hslot),
    .rdata_o (unused_hdr_rd)
  );

  assign out_valid_o     = out_valid_q;
  assign status_o_field  = res_status_q;
  assign result_pool_o   = res_pool_q;
  assign result_index_o  = res_idx_q;
  assign ref_count_now_o = res_refs_q;
  assign in_use_now_o    = res_use_q;
  assign peak_in_use_o   = res_peak_q;
  assign released_o      = res_rel_q;

endmodule
`default_nettype wire

// File: sv/refcounted_message_pool_allocator.sv
// top level of the refcounted message pool allocator
//
// Two pools of message descriptors (8 header-only entries, 16 payload
// entries), each with a LIFO free list, an in-use count and its peak, and an
// 8-bit saturating reference count per entry. Every accepted operation gives
// exactly one result. The controller captures the transaction in its idle
// state, then in its execute state, once the output is free, updates the free
// lists and counts and loads the result register. A new transaction can be
// taken while the previous result is still waiting, so a stalled output holds
// the block for as long as the stall lasts. The payload limit register may be
// written at any time the block is idle.
`default_nettype none
module refcounted_message_pool_allocator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rmpa_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    operation_i,
  input  wire logic [rmpa_pkg::FIELD_W-1:0]  dest_task_i,
  input  wire logic [rmpa_pkg::FIELD_W-1:0]  signal_code_i,
  input  wire logic [rmpa_pkg::FIELD_W-1:0]  payload_size_i,
  input  wire logic [rmpa_pkg::FIELD_W-1:0]  source_task_i,
  input  wire logic                          handle_pool_i,
  input  wire logic [rmpa_pkg::IDX_W-1:0]    handle_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         status_o,
  output logic                               result_pool_o,
  output logic [rmpa_pkg::IDX_W-1:0]         result_index_o,
  output logic [rmpa_pkg::REF_W-1:0]         ref_count_now_o,
  output logic [rmpa_pkg::CNT_W-1:0]         in_use_now_o,
  output logic [rmpa_pkg::CNT_W-1:0]         peak_in_use_o,
  output logic                               released_o
);
  import rmpa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  rmpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  rmpa_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .operation_i     (operation_i),
    .dest_task_i     (dest_task_i),
    .signal_code_i   (signal_code_i),
    .payload_size_i  (payload_size_i),
    .source_task_i   (source_task_i),
    .handle_pool_i   (handle_pool_i),
    .handle_index_i  (handle_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o_field  (status_o),
    .result_pool_o   (result_pool_o),
    .result_index_o  (result_index_o),
    .ref_count_now_o (ref_count_now_o),
    .in_use_now_o    (in_use_now_o),
    .peak_in_use_o   (peak_in_use_o),
    .released_o      (released_o)
  );

  // the peak never trails the live count of the pool reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> peak_in_use_o >= in_use_now_o)
    else $error("peak below in-use count");

  // a pool never reports more entries in use than it holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_use_now_o <= (result_pool_o ? CNT_W'(LARGE_UNITS)
                                                   : CNT_W'(SMALL_UNITS)))
    else $error("in-use count above pool size");

  // a released entry always reports success and a cleared count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && released_o) |-> (ref_count_now_o == '0 && status_o == ST_OK))
    else $error("release with nonzero count or failure status");

  // one transaction in flight: no accept in the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("back-to-back input accept");

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// testbench for the refcounted message pool allocator
module testbench;
  import rmpa_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DIR_ROWS    = 25;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    op_e                op;
    logic [FIELD_W-1:0] dest;
    logic [FIELD_W-1:0] sig;
    logic [FIELD_W-1:0] size;
    logic [FIELD_W-1:0] src;
    logic               hpool;
    logic [IDX_W-1:0]   hidx;
  } pool_req_t;

  typedef struct packed {
    status_e            status;
    logic               pool;
    logic [IDX_W-1:0]   index;
    logic [REF_W-1:0]   refs;
    logic [CNT_W-1:0]   in_use;
    logic [CNT_W-1:0]   peak;
    logic               released;
  } pool_outcome_t;

  typedef struct packed {
    pool_req_t     req;
    logic          typed;
    pool_outcome_t outcome;
  } dir_row_t;

  localparam pool_outcome_t NO_OUTCOME = '0;

  // directed rows; outcomes typed in only where they are obvious
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{OP_FREE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 4'd0}, 1'b1,
      '{ST_BAD_HANDLE, 1'b0, 4'd0, 8'd0, 5'd0, 5'd0, 1'b0}},
    '{'{OP_ADD_REF, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1, 4'd15}, 1'b1,
      '{ST_BAD_HANDLE, 1'b1, 4'd15, 8'd0, 5'd0, 5'd0, 1'b0}},
    '{'{OP_DROP_REF, 16'h1234, 16'h5678, 16'h0000, 16'h9abc, 1'b0, 4'd15}, 1'b1,
      '{ST_BAD_HANDLE, 1'b0, 4'd15, 8'd0, 5'd0, 5'd0, 1'b0}},
    '{'{OP_ALLOC, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 4'd15}, 1'b1,
      '{ST_OK, 1'b0, 4'd0, 8'd1, 5'd1, 5'd1, 1'b0}},
    '{'{OP_ALLOC, 16'hffff, 16'hffff, 16'd16, 16'hffff, 1'b1, 4'd15}, 1'b1,
      '{ST_OK, 1'b1, 4'd0, 8'd1, 5'd1, 5'd1, 1'b0}},
    '{'{OP_ALLOC, 16'h0011, 16'h0022, 16'd17, 16'h0033, 1'b0, 4'd0}, 1'b1,
      '{ST_TOO_LARGE, 1'b1, 4'd0, 8'd0, 5'd1, 5'd1, 1'b0}},
    '{'{OP_ALLOC, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0, 4'd0}, 1'b1,
      '{ST_TOO_LARGE, 1'b1, 4'd0, 8'd0, 5'd1, 5'd1, 1'b0}},
    '{'{OP_ALLOC, 16'h0100, 16'h0200, 16'd1, 16'h0300, 1'b0, 4'd0}, 1'b1,
      '{ST_OK, 1'b1, 4'd1, 8'd1, 5'd2, 5'd2, 1'b0}},
    '{'{OP_ADD_REF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 4'd1}, 1'b0, NO_OUTCOME},
    '{'{OP_DROP_REF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 4'd1}, 1'b0, NO_OUTCOME},
    '{'{OP_DROP_REF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 4'd1}, 1'b0, NO_OUTCOME},
    '{'{OP_FREE, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 1'b1, 4'd0}, 1'b0, NO_OUTCOME},
    '{'{OP_FREE, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 1'b1, 4'd0}, 1'b0, NO_OUTCOME},
    '{'{OP_ALLOC, 16'h0a0a, 16'h0b0b, 16'd5, 16'h0c0c, 1'b0, 4'd7}, 1'b0, NO_OUTCOME},
    '{'{OP_ALLOC, 16'h0001, 16'h0002, 16'h0000, 16'h0003, 1'b0, 4'd1}, 1'b0, NO_OUTCOME},
    '{'{OP_ALLOC, 16'h0004, 16'h0005, 16'h0000, 16'h0006, 1'b1, 4'd2}, 1'b0, NO_OUTCOME},
    '{'{OP_ALLOC, 16'h0007, 16'h0008, 16'h0000, 16'h0009, 1'b0, 4'd3}, 1'b0, NO_OUTCOME},
    '{'{OP_ALLOC, 16'h8000, 16'h4000, 16'h0000, 16'h2000, 1'b1, 4'd4}, 1'b0, NO_OUTCOME},
    '{'{OP_ALLOC, 16'h1000, 16'h0800, 16'h0000, 16'h0400, 1'b0, 4'd5}, 1'b0, NO_OUTCOME},
    '{'{OP_ALLOC, 16'h0200, 16'h0100, 16'h0000, 16'h0080, 1'b1, 4'd6}, 1'b0, NO_OUTCOME},
    '{'{OP_ALLOC, 16'h0040, 16'h0020, 16'h0000, 16'h0010, 1'b0, 4'd8}, 1'b0, NO_OUTCOME},
    '{'{OP_ALLOC, 16'hffff, 16'h0000, 16'h0000, 16'hffff, 1'b1, 4'd9}, 1'b1,
      '{ST_EXHAUSTED, 1'b0, 4'd0, 8'd0, 5'd8, 5'd8, 1'b0}},
    '{'{OP_FREE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 4'd3}, 1'b0, NO_OUTCOME},
    '{'{OP_ALLOC, 16'h00ff, 16'hff00, 16'h0000, 16'h0ff0, 1'b0, 4'd0}, 1'b0, NO_OUTCOME},
    '{'{OP_DROP_REF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 4'd8}, 1'b0, NO_OUTCOME}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               cfg_we    = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  pool_req_t          req_q     = '0;
  logic               row_typed = 1'b0;
  pool_outcome_t      row_outcome = '0;
  logic               out_ready = 1'b0;
  int                 recv_idle_pct = 0;
  logic               hold_req  = 1'b0;

  logic               in_ready_o;
  logic               out_valid_o;
  logic [1:0]         status_o;
  logic               result_pool_o;
  logic [IDX_W-1:0]   result_index_o;
  logic [REF_W-1:0]   ref_count_now_o;
  logic [CNT_W-1:0]   in_use_now_o;
  logic [CNT_W-1:0]   peak_in_use_o;
  logic               released_o;

  // predictor state
  logic [LINK_W-1:0]  free_head_q [2];
  logic [LINK_W-1:0]  next_link_q [2][16];
  logic [CNT_W-1:0]   in_use_cnt [2];
  logic [CNT_W-1:0]   peak_cnt [2];
  logic [REF_W-1:0]   ref_cnt [2][16];
  logic               busy [2][16];
  logic [LIMIT_W-1:0] limit_q;

  pool_outcome_t outcome_q [$];
  int            mismatches = 0;
  int            cycle_cnt = 0;
  int            send_idle_pct = 0;
  int            hold_left = 0;
  logic          hold_done = 1'b0;

  refcounted_message_pool_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .operation_i    (req_q.op),
    .dest_task_i    (req_q.dest),
    .signal_code_i  (req_q.sig),
    .payload_size_i (req_q.size),
    .source_task_i  (req_q.src),
    .handle_pool_i  (req_q.hpool),
    .handle_index_i (req_q.hidx),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .status_o       (status_o),
    .result_pool_o  (result_pool_o),
    .result_index_o (result_index_o),
    .ref_count_now_o(ref_count_now_o),
    .in_use_now_o   (in_use_now_o),
    .peak_in_use_o  (peak_in_use_o),
    .released_o     (released_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pool_size(logic p);
    return p ? LARGE_UNITS : SMALL_UNITS;
  endfunction

  // push a busy entry back onto the head of its free list
  function automatic void release_slot(logic p, logic [IDX_W-1:0] i);
    next_link_q[p][i] = free_head_q[p];
    free_head_q[p] = {1'b0, i};
    if (in_use_cnt[p] > 0) in_use_cnt[p] = in_use_cnt[p] - 1'b1;
    busy[p][i] = 1'b0;
    ref_cnt[p][i] = '0;
  endfunction

  function automatic pool_outcome_t pool_op_outcome(pool_req_t r);
    pool_outcome_t o;
    logic p;
    logic too_big;
    logic [LINK_W-1:0] head;
    o = '0;
    p = 1'b0;
    too_big = 1'b0;
    if (r.op == OP_ALLOC) begin
      if (r.size == '0) p = 1'b0;
      else if (r.size <= {8'd0, limit_q}) p = 1'b1;
      else too_big = 1'b1;
      if (too_big) begin
        o.status = ST_TOO_LARGE;
        o.pool = 1'b1;
      end else begin
        head = free_head_q[p];
        o.pool = p;
        if (head >= pool_size(p)) begin
          o.status = ST_EXHAUSTED;
        end else begin
          free_head_q[p] = next_link_q[p][head[IDX_W-1:0]];
          if (in_use_cnt[p] < CNT_MAX) in_use_cnt[p] = in_use_cnt[p] + 1'b1;
          if (in_use_cnt[p] > peak_cnt[p]) peak_cnt[p] = in_use_cnt[p];
          busy[p][head[IDX_W-1:0]] = 1'b1;
          ref_cnt[p][head[IDX_W-1:0]] = 8'd1;
          o.index = head[IDX_W-1:0];
          o.refs = 8'd1;
        end
      end
    end else begin
      o.pool = r.hpool;
      o.index = r.hidx;
      if (r.hidx >= pool_size(r.hpool) || !busy[r.hpool][r.hidx]) begin
        o.status = ST_BAD_HANDLE;
      end else begin
        case (r.op)
          OP_FREE: begin
            release_slot(r.hpool, r.hidx);
            o.released = 1'b1;
          end
          OP_ADD_REF: begin
            if (ref_cnt[r.hpool][r.hidx] < REF_MAX)
              ref_cnt[r.hpool][r.hidx] = ref_cnt[r.hpool][r.hidx] + 1'b1;
            o.refs = ref_cnt[r.hpool][r.hidx];
          end
          default: begin
            if (ref_cnt[r.hpool][r.hidx] > 0)
              ref_cnt[r.hpool][r.hidx] = ref_cnt[r.hpool][r.hidx] - 1'b1;
            if (ref_cnt[r.hpool][r.hidx] == '0) begin
              release_slot(r.hpool, r.hidx);
              o.released = 1'b1;
            end else begin
              o.refs = ref_cnt[r.hpool][r.hidx];
            end
          end
        endcase
      end
    end
    o.in_use = in_use_cnt[o.pool];
    o.peak = peak_cnt[o.pool];
    return o;
  endfunction

  // look for a live entry; the state may lag the stimulus a little
  function automatic bit pick_busy(output logic hp, output logic [IDX_W-1:0] hi);
    int start;
    int slot;
    start = $urandom_range(ENTRY_COUNT - 1);
    hp = 1'b0;
    hi = '0;
    for (int k = 0; k < ENTRY_COUNT; k++) begin
      slot = (start + k) % ENTRY_COUNT;
      if (slot >= SMALL_UNITS) begin
        if (busy[1][slot - SMALL_UNITS]) begin
          hp = 1'b1;
          hi = IDX_W'(slot - SMALL_UNITS);
          return 1'b1;
        end
      end else if (busy[0][slot]) begin
        hi = IDX_W'(slot);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_size(bit fitting);
    int x;
    x = $urandom_range(99);
    if (x < 30) return '0;
    if (x < 75 || fitting) begin
      if (limit_q == '0) return fitting ? 16'd0 : 16'($urandom_range(1, 3));
      return 16'($urandom_range(1, limit_q));
    end
    if (x < 88) return 16'(limit_q + 1 + $urandom_range(0, 3));
    return 16'($urandom_range(16'hffff));
  endfunction

  function automatic pool_req_t random_req();
    pool_req_t r;
    r.op    = op_e'($urandom_range(3));
    r.dest  = 16'($urandom_range(16'hffff));
    r.sig   = 16'($urandom_range(16'hffff));
    r.size  = 16'($urandom_range(16'hffff));
    r.src   = 16'($urandom_range(16'hffff));
    r.hpool = 1'($urandom_range(1));
    r.hidx  = 4'($urandom_range(15));
    return r;
  endfunction

  // checker and predictor, sampled at the clock edge
  always @(posedge clk_i) begin
    pool_outcome_t want;
    pool_outcome_t got;
    pool_outcome_t pred;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        got.status   = status_e'(status_o);
        got.pool     = result_pool_o;
        got.index    = result_index_o;
        got.refs     = ref_count_now_o;
        got.in_use   = in_use_now_o;
        got.peak     = peak_in_use_o;
        got.released = released_o;
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction at cycle %0d: st=%0d pool=%0d idx=%0d",
                     cycle_cnt, got.status, got.pool, got.index);
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch at cycle %0d: exp st=%0d pool=%0d idx=%0d ref=%0d ",
                        "use=%0d peak=%0d rel=%0d, got st=%0d pool=%0d idx=%0d ref=%0d ",
                        "use=%0d peak=%0d rel=%0d"}, cycle_cnt,
                       want.status, want.pool, want.index, want.refs, want.in_use,
                       want.peak, want.released, got.status, got.pool, got.index,
                       got.refs, got.in_use, got.peak, got.released);
          end
        end
      end
      if (in_valid && in_ready_o) begin
        pred = pool_op_outcome(req_q);
        outcome_q.push_back(row_typed ? row_outcome : pred);
      end
    end
  end

  // receiver with random stalls and one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic send_req(pool_req_t r, logic typed, pool_outcome_t o);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    req_q       <= r;
    row_typed   <= typed;
    row_outcome <= o;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (outcome_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    limit_q = v;
  endtask

  task automatic run_random(int n);
    int sent;
    int kind;
    int len;
    int x;
    bit to_small;
    pool_req_t r;
    logic hp;
    logic [IDX_W-1:0] hi;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(99);
      to_small = $urandom_range(1);
      if (kind < 55) len = $urandom_range(1, 8);
      else if (kind < 88) len = $urandom_range(6, 18);
      else len = $urandom_range(1, 4);
      for (int k = 0; k < len; k++) begin
        r = random_req();
        if (kind < 55) begin
          // mixed operations, mostly on live entries
          x = $urandom_range(99);
          r.op = (x < 35) ? OP_ALLOC : (x < 55) ? OP_FREE : (x < 78) ? OP_ADD_REF : OP_DROP_REF;
          if (r.op == OP_ALLOC) r.size = pick_size(1'b0);
          else if ($urandom_range(99) < 85 && pick_busy(hp, hi)) begin
            r.hpool = hp;
            r.hidx = hi;
          end
        end else if (kind < 70) begin
          // allocation flood, runs a pool dry
          r.op = OP_ALLOC;
          r.size = to_small ? 16'd0 : pick_size(1'b1);
        end else if (kind < 88) begin
          // release sweep over live entries
          r.op = $urandom_range(1) ? OP_FREE : OP_DROP_REF;
          if (pick_busy(hp, hi)) begin
            r.hpool = hp;
            r.hidx = hi;
          end
        end
        send_req(r, 1'b0, NO_OUTCOME);
        sent++;
      end
    end
  endtask

  initial begin
    pool_req_t r;
    logic hp;
    logic [IDX_W-1:0] hi;

    limit_q = LIMIT_RESET;
    for (int p = 0; p < 2; p++) begin
      free_head_q[p] = '0;
      in_use_cnt[p] = '0;
      peak_cnt[p] = '0;
      for (int i = 0; i < 16; i++) begin
        next_link_q[p][i] = (i + 1 < pool_size(p[0])) ? LINK_W'(i + 1) : LINK_END;
        ref_cnt[p][i] = '0;
        busy[p][i] = 1'b0;
      end
    end

    send_idle_pct = 23;
    recv_idle_pct <= 69;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++)
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].outcome);
    run_random(220);

    write_limit(8'd255);
    send_idle_pct = 69;
    recv_idle_pct <= 23;

    // drive one entry's reference count into saturation
    wait_idle();
    if (!pick_busy(hp, hi)) begin
      r = random_req();
      r.op = OP_ALLOC;
      r.size = '0;
      send_req(r, 1'b0, NO_OUTCOME);
      wait_idle();
      if (!pick_busy(hp, hi)) hi = '0;
    end
    for (int k = 0; k < 260; k++) begin
      r = random_req();
      r.op = (k < 256) ? OP_ADD_REF : (k < 259) ? OP_DROP_REF : OP_FREE;
      r.hpool = hp;
      r.hidx = hi;
      send_req(r, 1'b0, NO_OUTCOME);
    end
    run_random(100);

    write_limit(8'd0);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_random(60);

    write_limit(8'd1);
    run_random(80);

    write_limit(8'($urandom_range(2, 254)));
    hold_req <= 1'b1;
    run_random(130);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
